[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL module of the drive and intake controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/disc_pkg.sv]
// Package with the types, codes and constants of the drive and intake controller.
`timescale 1ns / 1ps

package disc_pkg;

    localparam int unsigned TIME_BITS_DEFAULT = 32;

    localparam int unsigned S_DATA_W  = 72;
    localparam int unsigned M_DATA_W  = 48;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEAD_ZONE      = 3'd0,
        REG_STALL_SPEED    = 3'd1,
        REG_RECOVER_SPEED  = 3'd2,
        REG_DEBOUNCE_TIME  = 3'd3,
        REG_KICKSTART_TIME = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_REVERSE,
        MODE_FORWARD,
        MODE_SPLIT,
        MODE_STOP
    } intake_mode_t;

    localparam logic [6:0]  DEAD_ZONE_RST      = 7'd8;
    localparam logic [12:0] STALL_SPEED_RST    = 13'd600;
    localparam logic [12:0] RECOVER_SPEED_RST  = 13'd650;
    localparam logic [15:0] DEBOUNCE_TIME_RST  = 16'd200;
    localparam logic [15:0] KICKSTART_TIME_RST = 16'd300;

    localparam logic signed [7:0] CMD_MAX          = 8'sd127;
    localparam logic signed [7:0] CMD_MIN          = -8'sd127;
    localparam logic signed [7:0] CMD_REV_INTAKE   = -8'sd90;
    localparam logic signed [7:0] CMD_REV_ROLLER   = -8'sd120;
    localparam logic signed [7:0] CMD_SLOW_ROLLER  = 8'sd30;
    localparam logic signed [7:0] CMD_SPLIT_LOWER  = 8'sd120;
    localparam logic signed [7:0] CMD_SPLIT_UPPER  = 8'sd40;
    localparam logic signed [7:0] CMD_SPLIT_ROLLER = -8'sd35;
    localparam logic signed [7:0] CMD_OFF          = 8'sd0;

endpackage

[hw/rtl/drive_intake_stall_control_core.sv]
// Top level of the drive and intake controller: stick mixing, intake modes and stall detection.
`timescale 1ns / 1ps

// One control tick enters per beat on the s_ channel and one result beat leaves on the m_
// channel. A tick is held in an input register, worked through in a single level of shallow
// logic and written, together with the controller state, into the result register; one tick
// can be taken every cycle while m_tready stays high. While a finished result waits for
// m_tready, one further tick is taken into the input register and s_tready then stays low
// until the waiting result leaves. Configuration registers are written through cfg_wr_en,
// cfg_addr and cfg_wr_data and must only be changed while no tick is in flight. Time
// differences are taken modulo 2^TIME_BITS.
module drive_intake_stall_control_core
    import disc_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // stick_forward[7:0], stick_turn[15:8], btn_split[16], btn_forward[17], btn_reverse[18],
    // btn_loader[19], press_ears[20], press_lift[21], press_descore[22],
    // roller_speed[36:23], time_now[68:37], zero fill[71:69]
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left_cmd[7:0], right_cmd[15:8], lower_intake_cmd[23:16], upper_intake_cmd[31:24],
    // roller_cmd[39:32], loader_out[40], ears_out[41], lift_out[42], descore_out[43],
    // full_mode[44], zero fill[47:45]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    `include "assert_macros.svh"

    localparam int unsigned TW = TIME_BITS;

    // Configuration registers.
    logic [6:0]  dead_zone_reg;
    logic [12:0] stall_speed_reg;
    logic [12:0] recover_speed_reg;
    logic [15:0] debounce_time_reg;
    logic [15:0] kickstart_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg      <= DEAD_ZONE_RST;
            stall_speed_reg    <= STALL_SPEED_RST;
            recover_speed_reg  <= RECOVER_SPEED_RST;
            debounce_time_reg  <= DEBOUNCE_TIME_RST;
            kickstart_time_reg <= KICKSTART_TIME_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DEAD_ZONE:      dead_zone_reg      <= cfg_wr_data[6:0];
                REG_STALL_SPEED:    stall_speed_reg    <= cfg_wr_data[12:0];
                REG_RECOVER_SPEED:  recover_speed_reg  <= cfg_wr_data[12:0];
                REG_DEBOUNCE_TIME:  debounce_time_reg  <= cfg_wr_data;
                REG_KICKSTART_TIME: kickstart_time_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input register and handshake.
    logic                in_valid_reg;
    logic [S_DATA_W-1:0] in_data_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    // Field extraction.
    logic signed [7:0]  stick_forward;
    logic signed [7:0]  stick_turn;
    logic               btn_split;
    logic               btn_forward;
    logic               btn_reverse;
    logic               btn_loader;
    logic               press_ears;
    logic               press_lift;
    logic               press_descore;
    logic signed [13:0] roller_speed;
    logic [31:0]        time_now;
    logic [TW-1:0]      now;

    assign stick_forward = in_data_reg[7:0];
    assign stick_turn    = in_data_reg[15:8];
    assign btn_split     = in_data_reg[16];
    assign btn_forward   = in_data_reg[17];
    assign btn_reverse   = in_data_reg[18];
    assign btn_loader    = in_data_reg[19];
    assign press_ears    = in_data_reg[20];
    assign press_lift    = in_data_reg[21];
    assign press_descore = in_data_reg[22];
    assign roller_speed  = in_data_reg[36:23];
    assign time_now      = in_data_reg[68:37];
    assign now           = TW'(time_now);

    // Drive mixing.
    logic signed [8:0] fwd_ext;
    logic signed [8:0] turn_ext;
    logic [8:0]        fwd_mag;
    logic [8:0]        turn_mag;
    logic signed [8:0] fwd_dz;
    logic signed [8:0] turn_dz;
    logic signed [8:0] left_sum;
    logic signed [8:0] right_sum;
    logic signed [7:0] left_cmd;
    logic signed [7:0] right_cmd;

    assign fwd_ext  = {stick_forward[7], stick_forward};
    assign turn_ext = {stick_turn[7], stick_turn};
    assign fwd_mag  = fwd_ext[8] ? 9'(-fwd_ext) : fwd_ext;
    assign turn_mag = turn_ext[8] ? 9'(-turn_ext) : turn_ext;
    assign fwd_dz   = (fwd_mag < {2'b00, dead_zone_reg}) ? 9'sd0 : fwd_ext;
    assign turn_dz  = (turn_mag < {2'b00, dead_zone_reg}) ? 9'sd0 : turn_ext;
    assign left_sum  = fwd_dz + turn_dz;
    assign right_sum = fwd_dz - turn_dz;

    always_comb begin
        if (left_sum > 9'sd127) begin
            left_cmd = CMD_MAX;
        end else if (left_sum < -9'sd127) begin
            left_cmd = CMD_MIN;
        end else begin
            left_cmd = left_sum[7:0];
        end
        if (right_sum > 9'sd127) begin
            right_cmd = CMD_MAX;
        end else if (right_sum < -9'sd127) begin
            right_cmd = CMD_MIN;
        end else begin
            right_cmd = right_sum[7:0];
        end
    end

    // Controller state.
    logic              ears_down_reg, ears_down_next;
    logic              lift_down_reg, lift_down_next;
    logic              descore_down_reg, descore_down_next;
    logic              roller_allowed_reg, roller_allowed_next;
    logic              press_valid_reg, press_valid_next;
    logic              change_valid_reg, change_valid_next;
    logic [TW-1:0]     press_start_reg, press_start_next;
    logic [TW-1:0]     change_start_reg, change_start_next;
    logic signed [7:0] last_lower_reg, last_lower_next;
    logic signed [7:0] last_upper_reg, last_upper_next;
    logic signed [7:0] last_roller_reg, last_roller_next;

    intake_mode_t mode;

    always_comb begin
        if (btn_reverse) begin
            mode = MODE_REVERSE;
        end else if (btn_forward) begin
            mode = MODE_FORWARD;
        end else if (btn_split) begin
            mode = MODE_SPLIT;
        end else begin
            mode = MODE_STOP;
        end
    end

    // Stall detector timing and speed checks.
    logic [14:0]   speed_mag;
    logic [TW-1:0] press_ref;
    logic [TW-1:0] change_ref;
    logic [TW-1:0] press_age;
    logic [TW-1:0] change_age;
    logic          kick_done;
    logic          debounce_done;
    logic          toward_slow;
    logic          toward_full;

    assign speed_mag     = roller_speed[13] ? 15'(-roller_speed) : {1'b0, roller_speed};
    assign press_ref     = press_valid_reg ? press_start_reg : now;
    assign change_ref    = change_valid_reg ? change_start_reg : now;
    assign press_age     = now - press_ref;
    assign change_age    = now - change_ref;
    assign kick_done     = {16'd0, press_age} > {{TW{1'b0}}, kickstart_time_reg};
    assign debounce_done = {16'd0, change_age} > {{TW{1'b0}}, debounce_time_reg};
    assign toward_slow   = roller_allowed_reg && (speed_mag < {2'b00, stall_speed_reg});
    assign toward_full   = !roller_allowed_reg && (speed_mag > {2'b00, recover_speed_reg});

    logic signed [7:0] intake_spd;
    logic signed [7:0] roller_spd;

    always_comb begin
        roller_allowed_next = roller_allowed_reg;
        press_valid_next    = press_valid_reg;
        press_start_next    = press_start_reg;
        change_valid_next   = change_valid_reg;
        change_start_next   = change_start_reg;
        intake_spd          = CMD_OFF;
        roller_spd          = CMD_OFF;
        unique case (mode)
            MODE_REVERSE: begin
                intake_spd          = CMD_REV_INTAKE;
                roller_spd          = CMD_REV_ROLLER;
                roller_allowed_next = 1'b1;
                press_valid_next    = 1'b0;
            end
            MODE_FORWARD: begin
                press_start_next = press_ref;
                press_valid_next = 1'b1;
                intake_spd       = CMD_MAX;
                roller_spd       = CMD_MAX;
                if (ears_down_reg) begin
                    if (kick_done) begin
                        if (toward_slow || toward_full) begin
                            change_start_next = change_ref;
                            change_valid_next = 1'b1;
                            if (debounce_done) begin
                                roller_allowed_next = toward_full;
                                change_valid_next   = 1'b0;
                            end
                        end else begin
                            change_valid_next = 1'b0;
                        end
                    end
                    if (!roller_allowed_next) begin
                        roller_spd = CMD_SLOW_ROLLER;
                    end
                end else begin
                    roller_allowed_next = 1'b1;
                end
            end
            MODE_SPLIT: begin
                press_valid_next = 1'b0;
            end
            MODE_STOP: begin
                roller_allowed_next = 1'b1;
                press_valid_next    = 1'b0;
            end
            default: ;
        endcase
    end

    // Motor commands are held while split is pressed together with another intake button.
    always_comb begin
        last_lower_next  = last_lower_reg;
        last_upper_next  = last_upper_reg;
        last_roller_next = last_roller_reg;
        if (!btn_split) begin
            last_lower_next  = intake_spd;
            last_upper_next  = intake_spd;
            last_roller_next = roller_spd;
        end else if (mode == MODE_SPLIT) begin
            last_lower_next  = CMD_SPLIT_LOWER;
            last_upper_next  = CMD_SPLIT_UPPER;
            last_roller_next = CMD_SPLIT_ROLLER;
        end
    end

    assign ears_down_next    = ears_down_reg ^ press_ears;
    assign lift_down_next    = lift_down_reg ^ press_lift;
    assign descore_down_next = descore_down_reg ^ press_descore;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ears_down_reg      <= 1'b0;
            lift_down_reg      <= 1'b0;
            descore_down_reg   <= 1'b0;
            roller_allowed_reg <= 1'b1;
            press_valid_reg    <= 1'b0;
            change_valid_reg   <= 1'b0;
            last_lower_reg     <= CMD_OFF;
            last_upper_reg     <= CMD_OFF;
            last_roller_reg    <= CMD_OFF;
        end else if (advance) begin
            ears_down_reg      <= ears_down_next;
            lift_down_reg      <= lift_down_next;
            descore_down_reg   <= descore_down_next;
            roller_allowed_reg <= roller_allowed_next;
            press_valid_reg    <= press_valid_next;
            change_valid_reg   <= change_valid_next;
            last_lower_reg     <= last_lower_next;
            last_upper_reg     <= last_upper_next;
            last_roller_reg    <= last_roller_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            press_start_reg  <= press_start_next;
            change_start_reg <= change_start_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'b000, roller_allowed_next, descore_down_next, lift_down_next,
                             ears_down_next, btn_loader, last_roller_next, last_upper_next,
                             last_lower_next, right_cmd, left_cmd};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_NOW(a_no_take_when_blocked, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `ASSERT_NEXT(a_allowed_after_rev_stop, aclk, aresetn,
        advance && (mode == MODE_REVERSE || mode == MODE_STOP), roller_allowed_reg)
    `ASSERT_NEXT(a_split_commands, aclk, aresetn,
        advance && mode == MODE_SPLIT, last_roller_reg == CMD_SPLIT_ROLLER)
    `ASSERT_NEXT(a_state_holds_idle, aclk, aresetn,
        !advance, $stable(roller_allowed_reg) && $stable(ears_down_reg))

endmodule

[verif/drive_intake_stall_control_core_tb.sv]
// Self-checking testbench of the drive and intake controller: stick mixing, intake modes and stall.
`timescale 1ns / 1ps

module drive_intake_stall_control_core_tb;
    import disc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [31:0]       now;
        logic signed [13:0] speed;
        logic              p_desc;
        logic              p_lift;
        logic              p_ears;
        logic              loader;
        logic              brev;
        logic              bfwd;
        logic              split;
        logic signed [7:0] turn;
        logic signed [7:0] fwd;
    } tick_t;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic signed [7:0] lower;
        logic signed [7:0] upper;
        logic signed [7:0] roller;
        logic              loader;
        logic              ears;
        logic              lift;
        logic              desc;
        logic              full;
    } cmd_set_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Settings and state as the block should hold them.
    logic [6:0]  dead_zone_q  = DEAD_ZONE_RST;
    logic [12:0] stall_q      = STALL_SPEED_RST;
    logic [12:0] recover_q    = RECOVER_SPEED_RST;
    logic [15:0] debounce_q   = DEBOUNCE_TIME_RST;
    logic [15:0] kick_q       = KICKSTART_TIME_RST;
    logic        ears_dn      = 1'b0;
    logic        lift_dn      = 1'b0;
    logic        desc_dn      = 1'b0;
    logic        full_ok      = 1'b1;
    logic [31:0] press_t      = '0;
    logic        press_v      = 1'b0;
    logic [31:0] change_t     = '0;
    logic        change_v     = 1'b0;
    logic signed [7:0] held_lower  = CMD_OFF;
    logic signed [7:0] held_upper  = CMD_OFF;
    logic signed [7:0] held_roller = CMD_OFF;

    cmd_set_t    due_commands[$];
    int          errors      = 0;
    int          items_sent  = 0;
    int          hold_asked  = 0;
    int          hold_done   = 0;
    logic        idle_en     = 1'b1;
    logic [31:0] ms_clock    = '0;

    drive_intake_stall_control_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic signed [7:0] clamp_cmd(int v);
        if (v > 127) return CMD_MAX;
        if (v < -127) return CMD_MIN;
        return v[7:0];
    endfunction

    function automatic cmd_set_t compute_commands(tick_t tk);
        int                f;
        int                t;
        int                spd;
        logic [31:0]       since_press;
        logic [31:0]       since_change;
        logic              toward_slow;
        logic              toward_full;
        logic signed [7:0] in_cmd;
        logic signed [7:0] rol_cmd;
        intake_mode_t      mode;
        cmd_set_t          r;
        f = int'(tk.fwd);
        t = int'(tk.turn);
        if ((f < 0 ? -f : f) < int'(dead_zone_q)) f = 0;
        if ((t < 0 ? -t : t) < int'(dead_zone_q)) t = 0;
        spd = int'(tk.speed);
        if (spd < 0) spd = -spd;
        r.left  = clamp_cmd(f + t);
        r.right = clamp_cmd(f - t);
        mode = tk.brev ? MODE_REVERSE : tk.bfwd ? MODE_FORWARD : tk.split ? MODE_SPLIT : MODE_STOP;
        in_cmd  = CMD_OFF;
        rol_cmd = CMD_OFF;
        case (mode)
            MODE_REVERSE: begin
                in_cmd  = CMD_REV_INTAKE;
                rol_cmd = CMD_REV_ROLLER;
                full_ok = 1'b1;
                press_v = 1'b0;
            end
            MODE_FORWARD: begin
                if (!press_v) begin
                    press_t = tk.now;
                    press_v = 1'b1;
                end
                in_cmd  = CMD_MAX;
                rol_cmd = CMD_MAX;
                if (ears_dn) begin
                    since_press = tk.now - press_t;
                    if (since_press > {16'b0, kick_q}) begin
                        toward_slow = full_ok && spd < int'(stall_q);
                        toward_full = !full_ok && spd > int'(recover_q);
                        if (toward_slow || toward_full) begin
                            if (!change_v) begin
                                change_t = tk.now;
                                change_v = 1'b1;
                            end
                            since_change = tk.now - change_t;
                            if (since_change > {16'b0, debounce_q}) begin
                                full_ok  = toward_full;
                                change_v = 1'b0;
                            end
                        end else begin
                            change_v = 1'b0;
                        end
                    end
                    if (!full_ok) rol_cmd = CMD_SLOW_ROLLER;
                end else begin
                    full_ok = 1'b1;
                end
            end
            MODE_SPLIT: begin
                held_lower  = CMD_SPLIT_LOWER;
                held_upper  = CMD_SPLIT_UPPER;
                held_roller = CMD_SPLIT_ROLLER;
                press_v     = 1'b0;
            end
            default: begin
                full_ok = 1'b1;
                press_v = 1'b0;
            end
        endcase
        if (!tk.split) begin
            held_lower  = in_cmd;
            held_upper  = in_cmd;
            held_roller = rol_cmd;
        end
        if (tk.p_ears) ears_dn = !ears_dn;
        if (tk.p_lift) lift_dn = !lift_dn;
        if (tk.p_desc) desc_dn = !desc_dn;
        r.lower  = held_lower;
        r.upper  = held_upper;
        r.roller = held_roller;
        r.loader = tk.loader;
        r.ears   = ears_dn;
        r.lift   = lift_dn;
        r.desc   = desc_dn;
        r.full   = full_ok;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        cmd_set_t got;
        cmd_set_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.left   = m_tdata[7:0];
            got.right  = m_tdata[15:8];
            got.lower  = m_tdata[23:16];
            got.upper  = m_tdata[31:24];
            got.roller = m_tdata[39:32];
            got.loader = m_tdata[40];
            got.ears   = m_tdata[41];
            got.lift   = m_tdata[42];
            got.desc   = m_tdata[43];
            got.full   = m_tdata[44];
            if (due_commands.size() == 0) begin
                $error("result beat arrived with no tick outstanding");
                errors++;
            end else begin
                want = due_commands.pop_front();
                check_field("left_cmd", int'(want.left), int'(got.left));
                check_field("right_cmd", int'(want.right), int'(got.right));
                check_field("lower_intake_cmd", int'(want.lower), int'(got.lower));
                check_field("upper_intake_cmd", int'(want.upper), int'(got.upper));
                check_field("roller_cmd", int'(want.roller), int'(got.roller));
                check_field("loader_out", int'(want.loader), int'(got.loader));
                check_field("ears_out", int'(want.ears), int'(got.ears));
                check_field("lift_out", int'(want.lift), int'(got.lift));
                check_field("descore_out", int'(want.desc), int'(got.desc));
                check_field("full_mode", int'(want.full), int'(got.full));
            end
        end
    end

    // The receiver stalls at random while idle_en is set and, when asked, holds off for a long stretch.
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_done) begin
                m_tready <= 1'b0;
                for (n = 1; n < HOLD_CYCLES; n++) @(negedge aclk);
                hold_done++;
            end else begin
                m_tready <= !(idle_en && $urandom_range(99) < 7);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("** drive_intake_stall_control_core: FAILED **");
        $finish;
    end

    task automatic send_tick(input tick_t tk);
        if (idle_en && $urandom_range(99) < 7) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(2)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, tk.now, tk.speed, tk.p_desc, tk.p_lift, tk.p_ears, tk.loader,
                     tk.brev, tk.bfwd, tk.split, tk.turn, tk.fwd};
        do @(posedge aclk); while (!s_tready);
        due_commands.push_back(compute_commands(tk));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_commands.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_DEAD_ZONE:     dead_zone_q = val[6:0];
            REG_STALL_SPEED:   stall_q     = val[12:0];
            REG_RECOVER_SPEED: recover_q   = val[12:0];
            REG_DEBOUNCE_TIME: debounce_q  = val;
            default:           kick_q      = val;
        endcase
    endtask

    task automatic set_config(input logic [15:0] dz, input logic [15:0] st,
                              input logic [15:0] rc, input logic [15:0] db,
                              input logic [15:0] ks);
        wait_drained();
        write_reg(REG_DEAD_ZONE, dz);
        write_reg(REG_STALL_SPEED, st);
        write_reg(REG_RECOVER_SPEED, rc);
        write_reg(REG_DEBOUNCE_TIME, db);
        write_reg(REG_KICKSTART_TIME, ks);
    endtask

    function automatic tick_t plain_tick(logic [31:0] now);
        tick_t tk;
        tk     = '0;
        tk.now = now;
        return tk;
    endfunction

    function automatic tick_t next_tick();
        ms_clock += $urandom_range(40, 5);
        return plain_tick(ms_clock);
    endfunction

    function automatic logic signed [13:0] pick_speed(int kind);
        int mag;
        case (kind)
            0: mag = (stall_q == 0) ? 0 : $urandom_range(int'(stall_q) - 1, 0);
            1: mag = (recover_q >= 8191) ? 8191 : $urandom_range(8191, int'(recover_q) + 1);
            default: mag = $urandom_range(8191, 0);
        endcase
        if ($urandom_range(1) == 1) mag = -mag;
        return mag[13:0];
    endfunction

    function automatic tick_t noise_tick();
        tick_t       tk;
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        tk.fwd   = a[7:0];
        tk.turn  = a[15:8];
        {tk.p_desc, tk.p_lift, tk.p_ears, tk.loader, tk.brev, tk.bfwd, tk.split} = a[22:16];
        tk.speed = ($urandom_range(31) == 0) ? 14'sh2000 : b[13:0];
        if ($urandom_range(3) == 0) ms_clock = $urandom;
        else ms_clock += $urandom_range(60);
        tk.now = ms_clock;
        return tk;
    endfunction

    // Forward held with the ears mostly down, so that the stall detector is exercised.
    task automatic forward_session();
        tick_t tk;
        int    len;
        int    kind;
        int    i;
        if (!ears_dn && $urandom_range(3) != 0) begin
            tk = next_tick();
            tk.p_ears = 1'b1;
            send_tick(tk);
        end
        if ($urandom_range(19) == 0) ms_clock = 32'hFFFF_FFFF - $urandom_range(400);
        len  = $urandom_range(60, 5);
        kind = $urandom_range(2);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0) kind = $urandom_range(2);
            tk        = next_tick();
            tk.fwd    = 8'($urandom_range(255));
            tk.turn   = 8'($urandom_range(255));
            tk.bfwd   = 1'b1;
            tk.split  = ($urandom_range(19) == 0);
            tk.brev   = ($urandom_range(49) == 0);
            tk.loader = 1'($urandom_range(1));
            tk.p_ears = ($urandom_range(29) == 0);
            tk.p_lift = ($urandom_range(9) == 0);
            tk.p_desc = ($urandom_range(9) == 0);
            tk.speed  = pick_speed(kind);
            send_tick(tk);
        end
        repeat ($urandom_range(3, 1)) begin
            tk       = next_tick();
            tk.split = 1'($urandom_range(1));
            tk.brev  = ($urandom_range(3) == 0);
            tk.speed = pick_speed(2);
            send_tick(tk);
        end
    endtask

    task automatic run_random(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) begin
            if ($urandom_range(9) < 7) forward_session();
            else repeat ($urandom_range(5, 1)) send_tick(noise_tick());
        end
    endtask

    task automatic test_drive_mix();
        tick_t tk;
        tk = plain_tick(32'd0);
        tk.fwd = 8'sd127;  tk.turn = 8'sd127;  send_tick(tk);
        tk.fwd = -8'sd128; tk.turn = -8'sd128; send_tick(tk);
        tk.fwd = 8'sd127;  tk.turn = -8'sd128; send_tick(tk);
        tk.fwd = 8'sd7;    tk.turn = -8'sd7;   send_tick(tk);
        tk.fwd = 8'sd8;    tk.turn = -8'sd8;   send_tick(tk);
    endtask

    task automatic test_intake_modes();
        tick_t tk;
        tk = plain_tick(32'd10);
        tk.brev = 1'b1;  send_tick(tk);
        tk.brev = 1'b0;  tk.bfwd = 1'b1; send_tick(tk);
        tk.bfwd = 1'b0;  tk.split = 1'b1; send_tick(tk);
        tk.bfwd = 1'b1;  send_tick(tk);
        tk.brev = 1'b1;  send_tick(tk);
        tk = plain_tick(32'd20);
        send_tick(tk);
    endtask

    task automatic test_piston_toggles();
        tick_t tk;
        tk = plain_tick(32'd30);
        tk.loader = 1'b1; tk.p_ears = 1'b1; tk.p_lift = 1'b1; tk.p_desc = 1'b1;
        send_tick(tk);
        tk.loader = 1'b0;
        send_tick(tk);
    endtask

    // Kickstart and debounce edges, ears raised mid-press, time zero and wrap.
    task automatic test_stall_detector();
        tick_t tk;
        tk = plain_tick(32'd0);
        tk.p_ears = !ears_dn;
        send_tick(tk);
        tk = plain_tick(32'd0);
        tk.bfwd = 1'b1;
        send_tick(tk);
        tk.now = 32'd301;                       send_tick(tk);
        tk.now = 32'd502; tk.speed = -14'sd100; send_tick(tk);
        tk.now = 32'd600; tk.speed = 14'sd650;  send_tick(tk);
        tk.now = 32'd700; tk.speed = -14'sd651; send_tick(tk);
        tk.now = 32'd901; tk.speed = 14'sd6000; tk.p_ears = 1'b1; send_tick(tk);
        tk = plain_tick(32'hFFFF_FF00);
        tk.brev = 1'b1; tk.p_ears = 1'b1;
        send_tick(tk);
        tk = plain_tick(32'hFFFF_FF00);
        tk.bfwd = 1'b1;
        send_tick(tk);
        tk.now = 32'h0000_002D; send_tick(tk);
        tk.now = 32'h0000_00F6; send_tick(tk);
        ms_clock = 32'h0000_0100;
    endtask

    task automatic test_zero_thresholds();
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(250);
    endtask

    task automatic test_full_thresholds();
        set_config(16'd127, 16'd8191, 16'd8191, 16'd65535, 16'd65535);
        run_random(200);
    endtask

    task automatic test_stall_recovery();
        set_config(16'd10, 16'd600, 16'd650, 16'd60, 16'd100);
        idle_en = 1'b0;
        run_random(450);
        idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_asked++;
        run_random(150);
    endtask

    task automatic test_random_settings();
        int k;
        for (k = 0; k < 3; k++) begin
            set_config(16'($urandom_range(127)), 16'($urandom_range(6000)),
                       16'($urandom_range(6000)), 16'($urandom_range(400)),
                       16'($urandom_range(600)));
            run_random(200);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_DEAD_ZONE;
        cfg_wr_data = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_drive_mix();
        test_intake_modes();
        test_piston_toggles();
        test_stall_detector();
        test_zero_thresholds();
        test_full_thresholds();
        test_stall_recovery();
        test_output_backpressure();
        test_random_settings();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0 && due_commands.size() == 0) begin
            $display("** drive_intake_stall_control_core: PASSED **");
        end else begin
            $display("** drive_intake_stall_control_core: FAILED **");
        end
        $finish;
    end

endmodule

[drive_intake_stall_control_core.f]
+incdir+hw/rtl
hw/rtl/disc_pkg.sv
hw/rtl/drive_intake_stall_control_core.sv
verif/drive_intake_stall_control_core_tb.sv
